// ----- rtl/ham_pkg.sv -----
// hilbert analytic signal package: sizes, twiddle table and arithmetic helpers
// used by the butterfly unit and the top level; no dependencies
package ham_pkg;

  localparam int POINTS      = 64;
  localparam int LOGP        = 6;
  localparam int SAMPLE_BITS = 16;
  localparam int AW          = LOGP;
  localparam int DW          = 32;
  localparam int TW          = 18;
  localparam int PW          = DW + TW;

  typedef logic [AW-1:0]          addr_t;
  typedef logic signed [DW-1:0]   data_t;
  typedef logic signed [TW-1:0]   twid_t;

  typedef struct packed {
    logic mul_a;
    logic mul_b;
    logic sum;
  } bfly_ctl_t;

  function automatic twid_t quarter_cos(input logic [4:0] m);
    twid_t v;
    unique case (m)
      5'd0:    v = 18'sd65536;
      5'd1:    v = 18'sd65220;
      5'd2:    v = 18'sd64277;
      5'd3:    v = 18'sd62714;
      5'd4:    v = 18'sd60547;
      5'd5:    v = 18'sd57798;
      5'd6:    v = 18'sd54491;
      5'd7:    v = 18'sd50660;
      5'd8:    v = 18'sd46341;
      5'd9:    v = 18'sd41576;
      5'd10:   v = 18'sd36410;
      5'd11:   v = 18'sd30893;
      5'd12:   v = 18'sd25080;
      5'd13:   v = 18'sd19024;
      5'd14:   v = 18'sd12785;
      5'd15:   v = 18'sd6424;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic twid_t twid_cos(input logic [4:0] m);
    if (m <= 5'd16) return quarter_cos(m);
    return -quarter_cos(5'd0 - m);
  endfunction

  function automatic twid_t twid_sin(input logic [4:0] m);
    if (m <= 5'd16) return quarter_cos(5'd16 - m);
    return quarter_cos(m - 5'd16);
  endfunction

  function automatic addr_t bit_rev(input addr_t a);
    addr_t r;
    for (int b = 0; b < AW; b++) r[b] = a[AW-1-b];
    return r;
  endfunction

  function automatic data_t sat_neg(input data_t x);
    if (x == {1'b1, {(DW-1){1'b0}}}) return {1'b0, {(DW-1){1'b1}}};
    return -x;
  endfunction

  function automatic data_t sat33(input logic signed [DW:0] x);
    if (x[DW] != x[DW-1]) return x[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    return x[DW-1:0];
  endfunction

  // spectrum rotation: dc and nyquist cleared, lower half times -j, upper half times +j
  function automatic logic [2*DW-1:0] jrot(input addr_t k, input data_t re, input data_t im);
    if (k == '0 || k == addr_t'(POINTS / 2)) return '0;
    if (k < addr_t'(POINTS / 2)) return {im, sat_neg(re)};
    return {sat_neg(im), re};
  endfunction

endpackage

// ----- rtl/ham_in_if.sv -----
// input channel of the hilbert unit: one sample per beat
// depends on nothing
interface ham_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;
  modport source(output valid, output sample_real, output sample_imag, input ready);
  modport sink(input valid, input sample_real, input sample_imag, output ready);
endinterface

// ----- rtl/ham_out_if.sv -----
// result channel of the hilbert unit: one frame index per beat
// depends on nothing
interface ham_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] original_value;
  logic signed [15:0] hilbert_value;
  logic               last_of_frame;
  modport source(output valid, output original_value, output hilbert_value,
                 output last_of_frame, input ready);
  modport sink(input valid, input original_value, input hilbert_value,
               input last_of_frame, output ready);
endinterface

// ----- rtl/ham_ram.sv -----
// generic single write, single read memory with registered read data
// no dependencies
module ham_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ham_bfly.sv -----
// radix-2 butterfly arithmetic: twiddle products registered under mul_a and mul_b,
// rounding, saturating sum and difference; uses ham_pkg
module ham_bfly import ham_pkg::*; (
  input  logic       clk,
  input  bfly_ctl_t  ctl,
  input  logic       inv,
  input  logic [4:0] m,
  input  data_t      er,
  input  data_t      ei,
  input  data_t      ore,
  input  data_t      oim,
  output data_t      sum_re,
  output data_t      sum_im,
  output data_t      dif_re,
  output data_t      dif_im
);

  logic signed [PW-1:0]  p0_r, p1_r, p2_r, p3_r;
  data_t                 tr_r, ti_r;
  twid_t                 c, s;
  data_t                 x, y;
  logic signed [PW-1:0]  pc, ps;
  logic signed [PW+1:0]  acc_re, acc_im;

  function automatic data_t round_sat(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] r;
    r = (v + (PW+2)'(32768)) >>> 16;
    if (r > (PW+2)'(32'sh7fffffff)) return {1'b0, {(DW-1){1'b1}}};
    if (r < -(PW+2)'(64'sh80000000)) return {1'b1, {(DW-1){1'b0}}};
    return r[DW-1:0];
  endfunction

  // forward transform uses the conjugate twiddle
  assign c  = twid_cos(m);
  assign s  = inv ? twid_sin(m) : -twid_sin(m);
  assign x  = ctl.mul_a ? ore : oim;
  assign y  = ctl.mul_a ? oim : ore;
  assign pc = x * c;
  assign ps = y * s;

  always_ff @(posedge clk) begin
    if (ctl.mul_a) begin
      p0_r <= pc;
      p1_r <= ps;
    end
    if (ctl.mul_b) begin
      p2_r <= pc;
      p3_r <= ps;
    end
    if (ctl.sum) begin
      tr_r <= round_sat(acc_re);
      ti_r <= round_sat(acc_im);
    end
  end

  assign acc_re = (PW+2)'(p0_r) - (PW+2)'(p1_r);
  assign acc_im = (PW+2)'(p2_r) + (PW+2)'(p3_r);

  assign sum_re = sat33((DW+1)'(er) + (DW+1)'(tr_r));
  assign sum_im = sat33((DW+1)'(ei) + (DW+1)'(ti_r));
  assign dif_re = sat33((DW+1)'(er) - (DW+1)'(tr_r));
  assign dif_im = sat33((DW+1)'(ei) - (DW+1)'(ti_r));

endmodule

// ----- rtl/hilbert_analytic_signal_unit.sv -----
// hilbert analytic signal unit: frame store, fft sequencer and result stage
// uses ham_pkg, ham_in_if, ham_out_if, ham_ram and ham_bfly
//
// usage
//   in_ch takes one complex sample per beat; a frame is 64 samples.
//   while a frame loads, ready is high every cycle.
//   after the last sample the block stops taking samples, runs a forward fft,
//   rotates the spectrum (dc and nyquist cleared, -j below, +j above), runs an
//   inverse fft, then sends 64 result beats on out_ch in index order, each with
//   the original real sample, the hilbert value (divided by 64, rounded,
//   saturated) and last_of_frame on index 63.
//   every butterfly reads both operands from two mirrored work memories in the
//   same cycle, forms the twiddle products in S_MA and S_MB, rounds in S_SUM,
//   and writes back in S_WE and S_WO on the single write port; 192 butterflies per fft.
//   the spectrum rotation pass reads each bit-reversed pair once, writes each
//   rotated value to its partner's index and skips an index whose partner is
//   lower; the result pass reads each entry, then loads the output register.
//   new samples are taken only after the last result beat is loaded; the frame
//   time is set mostly by the butterfly loop on the one write port.
//   a stalled receiver holds the output register; the result pass waits on it.
//   reset empties the output register and restarts loading at index 0; the
//   memories are not cleared, every entry is written before it is read.
module hilbert_analytic_signal_unit import ham_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ham_in_if.sink    in_ch,
  ham_out_if.source out_ch
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MA   = 4'd2;
  localparam logic [3:0] S_MB   = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_WE   = 4'd5;
  localparam logic [3:0] S_WO   = 4'd6;
  localparam logic [3:0] S_JRD  = 4'd7;
  localparam logic [3:0] S_JW1  = 4'd8;
  localparam logic [3:0] S_JW2  = 4'd9;
  localparam logic [3:0] S_ORD  = 4'd10;
  localparam logic [3:0] S_OWT  = 4'd11;

  localparam logic [2:0] LAST_STAGE = 3'(LOGP - 1);
  localparam logic [4:0] LAST_BF    = 5'(POINTS / 2 - 1);

  logic [3:0] state_r, state_nxt;
  addr_t      idx_r, idx_nxt;
  logic [2:0] st_r, st_nxt;
  logic [4:0] bf_r, bf_nxt;
  logic       inv_r, inv_nxt;

  logic       out_valid_r;
  logic signed [15:0] out_orig_r, out_hil_r;
  logic       out_last_r;

  // memory ports
  logic              w_we;
  addr_t             w_addr;
  logic [2*DW-1:0]   w_data;
  logic              rd_en;
  addr_t             ra_addr, rb_addr;
  logic [2*DW-1:0]   ra_data, rb_data;
  logic              o_we, o_re;
  logic [15:0]       o_rdata;

  // butterfly addressing
  addr_t      lo_mask, e_addr, o_addr, half_bit, rev_idx;
  logic [4:0] tw_m;
  bfly_ctl_t  bctl;
  data_t      sum_re, sum_im, dif_re, dif_im;

  logic       out_load;
  logic signed [DW:0]  hround;
  logic signed [DW:0]  hshift;
  logic signed [15:0]  hsat;

  assign half_bit = addr_t'(1) << st_r;
  assign lo_mask  = half_bit - addr_t'(1);
  assign e_addr   = ((addr_t'(bf_r) >> st_r) << (st_r + 3'd1)) | (addr_t'(bf_r) & lo_mask);
  assign o_addr   = e_addr | half_bit;
  assign tw_m     = 5'((addr_t'(bf_r) & lo_mask) << (3'd5 - st_r));
  assign rev_idx  = bit_rev(idx_r);

  assign bctl.mul_a = (state_r == S_MA);
  assign bctl.mul_b = (state_r == S_MB);
  assign bctl.sum   = (state_r == S_SUM);

  ham_bfly u_bfly (
    .clk    (clk),
    .ctl    (bctl),
    .inv    (inv_r),
    .m      (tw_m),
    .er     (data_t'(ra_data[2*DW-1:DW])),
    .ei     (data_t'(ra_data[DW-1:0])),
    .ore    (data_t'(rb_data[2*DW-1:DW])),
    .oim    (data_t'(rb_data[DW-1:0])),
    .sum_re (sum_re),
    .sum_im (sum_im),
    .dif_re (dif_re),
    .dif_im (dif_im)
  );

  // two mirrored work memories give two reads per cycle
  ham_ram #(.WIDTH(2*DW), .DEPTH(POINTS)) u_work_a (
    .clk(clk), .we(w_we), .waddr(w_addr), .wdata(w_data),
    .re(rd_en), .raddr(ra_addr), .rdata(ra_data)
  );

  ham_ram #(.WIDTH(2*DW), .DEPTH(POINTS)) u_work_b (
    .clk(clk), .we(w_we), .waddr(w_addr), .wdata(w_data),
    .re(rd_en), .raddr(rb_addr), .rdata(rb_data)
  );

  ham_ram #(.WIDTH(16), .DEPTH(POINTS)) u_orig (
    .clk(clk), .we(o_we), .waddr(idx_r), .wdata(in_ch.sample_real),
    .re(o_re), .raddr(idx_r), .rdata(o_rdata)
  );

  assign in_ch.ready = (state_r == S_LOAD);
  assign o_we        = in_ch.valid && in_ch.ready;
  assign o_re        = (state_r == S_ORD);

  // read side
  always_comb begin
    rd_en   = 1'b0;
    ra_addr = idx_r;
    rb_addr = rev_idx;
    unique case (state_r)
      S_RD: begin
        rd_en   = 1'b1;
        ra_addr = e_addr;
        rb_addr = o_addr;
      end
      S_JRD:   rd_en = (rev_idx >= idx_r);
      S_ORD:   rd_en = 1'b1;
      default: rd_en = 1'b0;
    endcase
  end

  // write side: load at bit-reversed index, butterflies, spectrum rotation
  always_comb begin
    w_we   = 1'b0;
    w_addr = idx_r;
    w_data = '0;
    unique case (state_r)
      S_LOAD: begin
        w_we   = o_we;
        w_addr = rev_idx;
        w_data = {DW'(in_ch.sample_real), DW'(in_ch.sample_imag)};
      end
      S_WE: begin
        w_we   = 1'b1;
        w_addr = e_addr;
        w_data = {sum_re, sum_im};
      end
      S_WO: begin
        w_we   = 1'b1;
        w_addr = o_addr;
        w_data = {dif_re, dif_im};
      end
      S_JW1: begin
        w_we   = 1'b1;
        w_addr = rev_idx;
        w_data = jrot(idx_r, ra_data[2*DW-1:DW], ra_data[DW-1:0]);
      end
      S_JW2: begin
        w_we   = 1'b1;
        w_addr = idx_r;
        w_data = jrot(rev_idx, rb_data[2*DW-1:DW], rb_data[DW-1:0]);
      end
      default: w_we = 1'b0;
    endcase
  end

  // result rounding: divide by the frame length, round half up, saturate
  assign hround = (DW+1)'(data_t'(ra_data[2*DW-1:DW])) + (DW+1)'(POINTS / 2);
  assign hshift = hround >>> LOGP;
  always_comb begin
    if (hshift > (DW+1)'((1 << (SAMPLE_BITS - 1)) - 1))
      hsat = {1'b0, {15{1'b1}}};
    else if (hshift < -(DW+1)'(1 << (SAMPLE_BITS - 1)))
      hsat = {1'b1, {15{1'b0}}};
    else
      hsat = hshift[15:0];
  end

  assign out_load = (state_r == S_OWT) && (!out_valid_r || out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    bf_nxt    = bf_r;
    inv_nxt   = inv_r;
    unique case (state_r)
      S_LOAD: begin
        if (o_we) begin
          idx_nxt = idx_r + addr_t'(1);
          if (idx_r == addr_t'(POINTS - 1)) begin
            state_nxt = S_RD;
            st_nxt    = '0;
            bf_nxt    = '0;
            inv_nxt   = 1'b0;
          end
        end
      end
      S_RD:  state_nxt = S_MA;
      S_MA:  state_nxt = S_MB;
      S_MB:  state_nxt = S_SUM;
      S_SUM: state_nxt = S_WE;
      S_WE:  state_nxt = S_WO;
      S_WO: begin
        state_nxt = S_RD;
        bf_nxt    = bf_r + 5'd1;
        if (bf_r == LAST_BF) begin
          bf_nxt = '0;
          st_nxt = st_r + 3'd1;
          if (st_r == LAST_STAGE) begin
            st_nxt    = '0;
            idx_nxt   = '0;
            state_nxt = inv_r ? S_ORD : S_JRD;
          end
        end
      end
      S_JRD: begin
        if (rev_idx >= idx_r) begin
          state_nxt = S_JW1;
        end else begin
          idx_nxt = idx_r + addr_t'(1);
        end
      end
      S_JW1: state_nxt = S_JW2;
      S_JW2: begin
        idx_nxt = idx_r + addr_t'(1);
        if (idx_r == addr_t'(POINTS - 1)) begin
          state_nxt = S_RD;
          inv_nxt   = 1'b1;
        end else begin
          state_nxt = S_JRD;
        end
      end
      S_ORD: state_nxt = S_OWT;
      S_OWT: begin
        if (out_load) begin
          idx_nxt   = idx_r + addr_t'(1);
          state_nxt = (idx_r == addr_t'(POINTS - 1)) ? S_LOAD : S_ORD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      idx_r       <= '0;
      st_r        <= '0;
      bf_r        <= '0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      st_r    <= st_nxt;
      bf_r    <= bf_nxt;
      inv_r   <= inv_nxt;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_orig_r <= o_rdata;
      out_hil_r  <= hsat;
      out_last_r <= (idx_r == addr_t'(POINTS - 1));
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.original_value = out_orig_r;
  assign out_ch.hilbert_value  = out_hil_r;
  assign out_ch.last_of_frame  = out_last_r;

endmodule
